FILE: hw/rtl/aws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_pkg: shared types and constants for the shake detector
// Window geometry, field widths, register indexes and the window entry type.
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int WINDOW_PAIRS = 16;
  localparam int SAMPLE_BITS  = 16;

  localparam int DELTA_W = SAMPLE_BITS;                    // |a-b| of two samples
  localparam int NOISE_W = SAMPLE_BITS + 2;                // dx+dy+dz
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_PAIRS);
  localparam int COUNT_W = $clog2(WINDOW_PAIRS + 1);
  localparam int SEEN_W  = $clog2(WINDOW_PAIRS + 2);
  localparam int CFG_W   = (SUM_W > NOISE_W) ? SUM_W : NOISE_W;
  localparam int IDX_W   = 3;

  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WINDOW_PAIRS + 1);

  localparam logic [IDX_W-1:0] REG_NOISE_THRESHOLD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_THRESHOLD_X      = 3'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD_Y      = 3'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD_Z      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_MOTION_COUNT = 3'd4;

  typedef struct packed {
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0] dz;
    logic               motion;
  } pair_t;

  // Delta stage to accumulator
  typedef struct packed {
    logic  pair;   // a previous sample existed, entry is real
    logic  full;   // window already holds WINDOW_PAIRS entries
    pair_t entry;
  } stage_t;

endpackage
`default_nettype wire

FILE: hw/rtl/aws_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_sample_if: accelerometer sample channel
// Valid/ready channel carrying one signed 3-axis sample per transaction.
// ----------------------------------------------------------------------------
interface aws_sample_if import aws_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/aws_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_result_if: shake detector result channel
// Valid/ready channel carrying window sums, motion count and shake flag.
// ----------------------------------------------------------------------------
interface aws_result_if import aws_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [SUM_W-1:0]   sum_z;
  logic [COUNT_W-1:0] motion_count;
  logic               shake_detected;

  modport source (output valid, output sum_x, output sum_y, output sum_z,
                  output motion_count, output shake_detected, input ready);
  modport sink   (input valid, input sum_x, input sum_y, input sum_z,
                  input motion_count, input shake_detected, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/aws_delta.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_delta: sample delta stage
// Holds the previous sample, forms per-axis absolute deltas and the motion
// bit, and registers them with window occupancy for the accumulator.
// ----------------------------------------------------------------------------
module aws_delta import aws_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          advance,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_z,
  input  wire logic        [NOISE_W-1:0]     noise_threshold,
  output logic                               stage_valid,
  output stage_t                             stage,
  output logic             [SEEN_W-1:0]      seen
);

  logic signed [SAMPLE_BITS-1:0] prev_x;
  logic signed [SAMPLE_BITS-1:0] prev_y;
  logic signed [SAMPLE_BITS-1:0] prev_z;
  pair_t                         entry_next;
  logic        [NOISE_W-1:0]     total;

  function automatic logic [DELTA_W-1:0] abs_diff(logic signed [SAMPLE_BITS-1:0] a,
                                                  logic signed [SAMPLE_BITS-1:0] b);
    logic signed [SAMPLE_BITS:0] d;
    logic        [SAMPLE_BITS:0] m;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    m = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
    return m[DELTA_W-1:0];
  endfunction

  always_comb begin
    entry_next.dx = abs_diff(sample_x, prev_x);
    entry_next.dy = abs_diff(sample_y, prev_y);
    entry_next.dz = abs_diff(sample_z, prev_z);
    total = NOISE_W'(entry_next.dx) + NOISE_W'(entry_next.dy) + NOISE_W'(entry_next.dz);
    entry_next.motion = total > noise_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      seen        <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
    end else if (accept) begin
      stage_valid <= 1'b1;
      if (seen != SEEN_MAX) begin
        seen <= seen + 1'b1;
      end
      prev_x <= sample_x;
      prev_y <= sample_y;
      prev_z <= sample_z;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.pair  <= seen != '0;
      stage.full  <= seen == SEEN_MAX;
      stage.entry <= entry_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/aws_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_cell: one window cell
// Holds one pair entry; takes its neighbor's entry on every window shift.
// ----------------------------------------------------------------------------
module aws_cell import aws_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift,
  input  wire pair_t din,
  output pair_t      dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/aws_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aws_window: delta window as a chain of cells
// Newest pair enters cell 0; the entry in the last cell is the oldest pair.
// ----------------------------------------------------------------------------
module aws_window import aws_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift,
  input  wire pair_t newest,
  output pair_t      oldest
);

  pair_t tap [WINDOW_PAIRS+1];

  assign tap[0] = newest;

  for (genvar i = 0; i < WINDOW_PAIRS; i++) begin : g_cell
    aws_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (tap[i]),
      .dout  (tap[i+1])
    );
  end

  assign oldest = tap[WINDOW_PAIRS];

endmodule
`default_nettype wire

FILE: hw/rtl/accel_window_shake_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accel_window_shake_detector: sliding-window shake detector
// Accumulates absolute sample deltas over a window and flags shaking.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless the result channel stalls it, and returns
// one result per sample: a delta stage forms the per-axis deltas against the
// previous sample, then the accumulator adds the newest pair, subtracts the
// pair leaving the window and shifts the 16-cell window chain. Results wait in
// the output register under back-pressure while one more sample is held in the
// delta stage. Thresholds are compared against the registered sums; write the
// configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module accel_window_shake_detector import aws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  aws_sample_if.sink            sample,
  aws_result_if.source          result
);

  logic [NOISE_W-1:0] noise_threshold;
  logic [SUM_W-1:0]   threshold_x;
  logic [SUM_W-1:0]   threshold_y;
  logic [SUM_W-1:0]   threshold_z;
  logic [COUNT_W-1:0] min_motion_count;

  logic               accept;
  logic               advance;
  logic               stage_valid;
  stage_t             stage;
  logic [SEEN_W-1:0]  seen;
  pair_t              oldest;
  pair_t              leaving;
  logic               shift;

  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [SUM_W-1:0]   sum_z;
  logic [COUNT_W-1:0] motion_count;
  logic [SUM_W-1:0]   sum_x_next;
  logic [SUM_W-1:0]   sum_y_next;
  logic [SUM_W-1:0]   sum_z_next;
  logic [COUNT_W-1:0] motion_count_next;
  logic               out_valid;
  logic [SEEN_W-1:0]  pairs_taken;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_threshold  <= '0;
      threshold_x      <= '0;
      threshold_y      <= '0;
      threshold_z      <= '0;
      min_motion_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_THRESHOLD:  noise_threshold <= cfg_data[NOISE_W-1:0];
        REG_THRESHOLD_X:      threshold_x     <= cfg_data[SUM_W-1:0];
        REG_THRESHOLD_Y:      threshold_y     <= cfg_data[SUM_W-1:0];
        REG_THRESHOLD_Z:      threshold_z     <= cfg_data[SUM_W-1:0];
        REG_MIN_MOTION_COUNT: begin
          if (cfg_data[COUNT_W-1:0] > COUNT_W'(WINDOW_PAIRS)) begin
            min_motion_count <= COUNT_W'(WINDOW_PAIRS);
          end else begin
            min_motion_count <= cfg_data[COUNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign advance      = stage_valid && (!out_valid || result.ready);
  assign sample.ready = !stage_valid || advance;
  assign accept       = sample.valid && sample.ready;
  assign shift        = advance && stage.pair;

  aws_delta u_delta (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .advance         (advance),
    .sample_x        (sample.sample_x),
    .sample_y        (sample.sample_y),
    .sample_z        (sample.sample_z),
    .noise_threshold (noise_threshold),
    .stage_valid     (stage_valid),
    .stage           (stage),
    .seen            (seen)
  );

  aws_window u_window (
    .clk    (clk),
    .shift  (shift),
    .newest (stage.entry),
    .oldest (oldest)
  );

  // add newest, subtract the pair falling out of a full window
  always_comb begin
    leaving = stage.full ? oldest : '0;
    sum_x_next = sum_x + SUM_W'(stage.entry.dx) - SUM_W'(leaving.dx);
    sum_y_next = sum_y + SUM_W'(stage.entry.dy) - SUM_W'(leaving.dy);
    sum_z_next = sum_z + SUM_W'(stage.entry.dz) - SUM_W'(leaving.dz);
    motion_count_next = motion_count + COUNT_W'(stage.entry.motion)
                        - COUNT_W'(leaving.motion);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      motion_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (shift) begin
        sum_x        <= sum_x_next;
        sum_y        <= sum_y_next;
        sum_z        <= sum_z_next;
        motion_count <= motion_count_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.sum_x          = sum_x;
  assign result.sum_y          = sum_y;
  assign result.sum_z          = sum_z;
  assign result.motion_count   = motion_count;
  assign result.shake_detected = (sum_x > threshold_x) && (sum_y > threshold_y) &&
                                 (sum_z > threshold_z) &&
                                 (motion_count > min_motion_count);

  assign pairs_taken = (seen == '0) ? '0 : seen - 1'b1;

  // motion count never exceeds the number of pairs taken so far
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    motion_count <= pairs_taken)
    else $error("motion count exceeds pairs taken");

  // a held delta stage blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && !result.ready) |-> !sample.ready)
    else $error("sample accepted while delta stage stalled");

  // subtraction of the oldest pair only once the window is full
  a_full_seen: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage.full) |-> (seen == SEEN_MAX))
    else $error("window full flag without full occupancy");

  // stalled result keeps its sums
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> $stable(sum_x) && $stable(motion_count))
    else $error("result sums changed under back-pressure");

endmodule
`default_nettype wire

FILE: tb/tb_accel_window_shake_detector.sv
// ----------------------------------------------------------------------------
// tb_accel_window_shake_detector: shake detector testbench
// Streams accelerometer samples through the detector under random idle and
// back-pressure, tracks the delta window alongside the block and checks
// every sums/count/flag transaction. Starts with hand-picked samples (first
// sample, filling and wrap of the window, extremes), then runs random bursts
// of quiet, shaking and extreme motion under several threshold settings.
// ----------------------------------------------------------------------------
module tb_accel_window_shake_detector;
  import aws_pkg::*;

  localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN  = -(2 ** (SAMPLE_BITS - 1));
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] z;
  } accel_sample_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_z;
    logic [COUNT_W-1:0] motion_count;
    logic               shake;
  } window_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  aws_sample_if sample_bus ();
  aws_result_if result_bus ();

  accel_window_shake_detector uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_bus),
    .result    (result_bus)
  );

  // register shadow
  logic [NOISE_W-1:0] noise_cfg = '0;
  logic [SUM_W-1:0]   thr_x     = '0;
  logic [SUM_W-1:0]   thr_y     = '0;
  logic [SUM_W-1:0]   thr_z     = '0;
  logic [COUNT_W-1:0] min_count = '0;

  // window shadow
  int          last_sample[3] = '{0, 0, 0};
  pair_t       delta_window[WINDOW_PAIRS];
  int unsigned acc_x        = 0;
  int unsigned acc_y        = 0;
  int unsigned acc_z        = 0;
  int unsigned motion_pairs = 0;
  int unsigned pairs_seen   = 0;
  int unsigned window_slot  = 0;

  accel_sample_t  sample_backlog[$];
  window_result_t predicted_windows[$];
  accel_sample_t  presented;
  window_result_t observed;
  window_result_t wanted;

  int samples_in_flight = 0;
  int error_count       = 0;
  int results_seen      = 0;
  int stall_cycles      = 0;
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic window_result_t predict_window(accel_sample_t s);
    int             cur[3];
    int             delta[3];
    int unsigned    total;
    pair_t          fresh;
    pair_t          oldest;
    window_result_t r;
    cur[0] = int'($signed(s.x));
    cur[1] = int'($signed(s.y));
    cur[2] = int'($signed(s.z));
    if (pairs_seen >= 1) begin
      total = 0;
      for (int a = 0; a < 3; a++) begin
        delta[a] = cur[a] - last_sample[a];
        if (delta[a] < 0) delta[a] = -delta[a];
        total += delta[a];
      end
      fresh.dx     = DELTA_W'(delta[0]);
      fresh.dy     = DELTA_W'(delta[1]);
      fresh.dz     = DELTA_W'(delta[2]);
      fresh.motion = total > noise_cfg;
      // window full: drop the oldest pair before storing the newest
      if (pairs_seen >= WINDOW_PAIRS + 1) begin
        oldest = delta_window[window_slot];
        acc_x -= oldest.dx;
        acc_y -= oldest.dy;
        acc_z -= oldest.dz;
        if (oldest.motion) motion_pairs--;
      end
      acc_x += fresh.dx;
      acc_y += fresh.dy;
      acc_z += fresh.dz;
      if (fresh.motion) motion_pairs++;
      delta_window[window_slot] = fresh;
      window_slot = (window_slot + 1) % WINDOW_PAIRS;
    end
    if (pairs_seen < WINDOW_PAIRS + 1) pairs_seen++;
    last_sample = cur;
    r.sum_x        = SUM_W'(acc_x);
    r.sum_y        = SUM_W'(acc_y);
    r.sum_z        = SUM_W'(acc_z);
    r.motion_count = COUNT_W'(motion_pairs);
    r.shake        = (acc_x > thr_x) && (acc_y > thr_y) && (acc_z > thr_z) &&
                     (motion_pairs > min_count);
    return r;
  endfunction

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid    <= 1'b0;
      sample_bus.sample_x <= '0;
      sample_bus.sample_y <= '0;
      sample_bus.sample_z <= '0;
    end else begin
      if (sample_bus.valid && sample_bus.ready)
        predicted_windows.push_back(predict_window(presented));
      if (!sample_bus.valid || sample_bus.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          presented = sample_backlog.pop_front();
          sample_bus.valid    <= 1'b1;
          sample_bus.sample_x <= presented.x;
          sample_bus.sample_y <= presented.y;
          sample_bus.sample_z <= presented.z;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        observed.sum_x        = result_bus.sum_x;
        observed.sum_y        = result_bus.sum_y;
        observed.sum_z        = result_bus.sum_z;
        observed.motion_count = result_bus.motion_count;
        observed.shake        = result_bus.shake_detected;
        if (predicted_windows.size() == 0) begin
          note_error($sformatf("result %0d with none pending: sums %0d/%0d/%0d count %0d shake %0b",
                               results_seen, observed.sum_x, observed.sum_y, observed.sum_z,
                               observed.motion_count, observed.shake));
        end else begin
          wanted = predicted_windows.pop_front();
          if (observed.sum_x !== wanted.sum_x || observed.sum_y !== wanted.sum_y ||
              observed.sum_z !== wanted.sum_z ||
              observed.motion_count !== wanted.motion_count ||
              observed.shake !== wanted.shake)
            note_error($sformatf(
              "result %0d: expected sums %0d/%0d/%0d count %0d shake %0b, got %0d/%0d/%0d count %0d shake %0b",
              results_seen, wanted.sum_x, wanted.sum_y, wanted.sum_z, wanted.motion_count,
              wanted.shake, observed.sum_x, observed.sum_y, observed.sum_z,
              observed.motion_count, observed.shake));
        end
        results_seen++;
        if (samples_in_flight > 0) samples_in_flight--;
      end
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NOISE_THRESHOLD: noise_cfg = data[NOISE_W-1:0];
      REG_THRESHOLD_X:     thr_x = data[SUM_W-1:0];
      REG_THRESHOLD_Y:     thr_y = data[SUM_W-1:0];
      REG_THRESHOLD_Z:     thr_z = data[SUM_W-1:0];
      REG_MIN_MOTION_COUNT:
        min_count = (data[COUNT_W-1:0] > WINDOW_PAIRS) ? COUNT_W'(WINDOW_PAIRS)
                                                       : data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input int unsigned noise, input int unsigned tx,
                                input int unsigned ty, input int unsigned tz,
                                input int unsigned min_pairs);
    write_reg(REG_NOISE_THRESHOLD, CFG_W'(noise));
    write_reg(REG_THRESHOLD_X, CFG_W'(tx));
    write_reg(REG_THRESHOLD_Y, CFG_W'(ty));
    write_reg(REG_THRESHOLD_Z, CFG_W'(tz));
    write_reg(REG_MIN_MOTION_COUNT, CFG_W'(min_pairs));
  endtask

  // indexes past the register list must leave every register alone
  task automatic write_unused_regs(input logic [CFG_W-1:0] data);
    for (int i = REG_MIN_MOTION_COUNT + 1; i < 2 ** IDX_W; i++)
      write_reg(IDX_W'(i), data);
  endtask

  task automatic wait_drained();
    while (samples_in_flight != 0) @(posedge clk);
  endtask

  function automatic int clamp_sample(int v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic int random_sample();
    return int'($signed(SAMPLE_BITS'($urandom)));
  endfunction

  function automatic int random_extreme();
    return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  function automatic void queue_sample(int x, int y, int z);
    accel_sample_t s;
    s.x = SAMPLE_BITS'(x);
    s.y = SAMPLE_BITS'(y);
    s.z = SAMPLE_BITS'(z);
    sample_backlog.push_back(s);
    samples_in_flight++;
  endfunction

  // One burst of motion; returns the number of samples queued
  function automatic int queue_burst();
    int kind;
    int len;
    int amp;
    int swing;
    int bx;
    int by;
    int bz;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(4, 40);
    bx   = random_sample();
    by   = random_sample();
    bz   = random_sample();
    amp  = (kind <= 3) ? (1 << $urandom_range(0, 8)) : (1 << $urandom_range(9, 15));
    for (int i = 0; i < len; i++) begin
      swing = (i % 2) ? amp : -amp;
      case (kind)
        0, 1, 2, 3: // resting, sensor noise only
          queue_sample(clamp_sample(bx + int'($urandom_range(0, 2 * amp)) - amp),
                       clamp_sample(by + int'($urandom_range(0, 2 * amp)) - amp),
                       clamp_sample(bz + int'($urandom_range(0, 2 * amp)) - amp));
        4, 5, 6: // shaking back and forth
          queue_sample(clamp_sample(bx + swing + int'($urandom_range(0, 255)) - 128),
                       clamp_sample(by - swing + int'($urandom_range(0, 255)) - 128),
                       clamp_sample(bz + swing + int'($urandom_range(0, 255)) - 128));
        7:       queue_sample(random_sample(), random_sample(), random_sample());
        8:       queue_sample(bx, by, bz);
        default: queue_sample(random_extreme(), random_extreme(), random_extreme());
      endcase
    end
    return len;
  endfunction

  task automatic run_random_phase(input int count);
    int queued;
    queued = 0;
    while (queued < count) queued += queue_burst();
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_unused_regs(CFG_W'($urandom));

    send_idle_pct = 37;
    recv_idle_pct = 49;

    // Directed: first sample, window fill with largest deltas, wrap, small steps
    queue_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
    for (int i = 0; i < WINDOW_PAIRS + 1; i++) begin
      if (i % 2 == 0) queue_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
      else            queue_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);
    end
    queue_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
    queue_sample(0, 0, 0);
    queue_sample(-1, -1, -1);
    queue_sample(-1, 0, -1);
    queue_sample(1, 1, 1);
    queue_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    wait_drained();

    write_settings(500, 20000, 20000, 20000, 4);
    run_random_phase(PHASE_ITEMS);

    write_settings($urandom_range(0, 2 ** NOISE_W - 1), $urandom_range(0, 300000),
                   $urandom_range(0, 300000), $urandom_range(0, 300000),
                   $urandom_range(0, WINDOW_PAIRS));
    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 49;
    recv_idle_pct = 37;

    // all ones: thresholds out of reach, count baseline clamped
    write_settings(2 ** CFG_W - 1, 2 ** CFG_W - 1, 2 ** CFG_W - 1, 2 ** CFG_W - 1,
                   2 ** CFG_W - 1);
    write_unused_regs('0);
    run_random_phase(PHASE_ITEMS);

    write_settings($urandom_range(0, 60000), $urandom_range(0, 400000),
                   $urandom_range(0, 400000), $urandom_range(0, 400000),
                   $urandom_range(0, 2 ** COUNT_W - 1));
    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;

    write_settings(0, $urandom_range(0, 100000), $urandom_range(0, 100000),
                   $urandom_range(0, 100000), WINDOW_PAIRS - 1);
    run_random_phase(PHASE_ITEMS);

    write_settings($urandom_range(0, 60000), $urandom_range(0, 400000),
                   $urandom_range(0, 400000), $urandom_range(0, 400000),
                   $urandom_range(0, 2 ** COUNT_W - 1));
    run_random_phase(PHASE_ITEMS);

    repeat (8) @(posedge clk);
    if (predicted_windows.size() != 0)
      note_error($sformatf("%0d results never arrived", predicted_windows.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: accel_window_shake_detector.f
hw/rtl/aws_pkg.sv
hw/rtl/aws_sample_if.sv
hw/rtl/aws_result_if.sv
hw/rtl/aws_delta.sv
hw/rtl/aws_cell.sv
hw/rtl/aws_window.sv
hw/rtl/accel_window_shake_detector.sv
tb/tb_accel_window_shake_detector.sv
